@@ design/llrs_pkg.sv @@
package llrs_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_SELECT = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [1:0] MODE_RANDOM   = 2'd1;
    localparam logic [1:0] MODE_REQUESTS = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] session_id;
        logic [31:0] buffer_size;
        logic [63:0] send_time;
        logic [31:0] sent_count;
        logic [31:0] request_count;
        logic [15:0] random_value;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] chosen_session;
        logic [31:0] chosen_buffer_size;
        logic [4:0]  entry_count;
    } t_out;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] buffer_size;
        logic [63:0] send_time;
        logic [31:0] sent_count;
        logic [31:0] request_count;
    } t_entry;

endpackage

@@ design/least_loaded_routee_selector_unit.sv @@
// channel  | signals                      | transfer
// input    | i_valid, o_ready, i_data     | item taken when i_valid and o_ready
// output   | o_valid, i_ready, o_data     | item taken when o_valid and i_ready
// config   | i_cfg_we, i_cfg_wdata        | select mode written when i_cfg_we
// add writes the new entry's id; remove and update scan ids at one entry a cycle through the
// table ram read port, then remove moves each later entry down one a cycle. select runs a
// bit-serial modulo of the random value, then reads the start entry and, except in random
// mode, every entry in turn. one item at a time; o_ready is low while busy.
// a result waits in the output register; the next item may run until its own result
// is due. synchronous active low reset clears count, request valid bits and control.
module least_loaded_routee_selector_unit #(
    parameter int MAX_ROUTEES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  llrs_pkg::t_in i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output llrs_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_wdata
);
    import llrs_pkg::*;

    localparam int AW = (MAX_ROUTEES > 1) ? $clog2(MAX_ROUTEES) : 1;
    localparam int CW = $clog2(MAX_ROUTEES + 1);
    localparam int EW = $bits(t_entry);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_MOD   = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]             r_state;
    t_in                    r_in;
    logic [1:0]             r_mode;
    logic [CW-1:0]          r_total;
    logic [MAX_ROUTEES-1:0] r_reqv;
    logic [CW-1:0]          r_idx;
    logic [AW-1:0]          r_start;
    logic                   r_first;
    logic                   r_issue;
    logic                   r_pv;
    logic                   r_pfirst;
    logic [AW-1:0]          r_pidx;
    logic [AW-1:0]          r_k;
    logic                   r_found;
    logic [CW-1:0]          r_rem;
    logic [15:0]            r_dvd;
    logic [4:0]             r_cnt;
    logic [1:0]             r_status;
    logic [15:0]            r_cid;
    logic [31:0]            r_cbuf;
    logic [63:0]            r_ctime;
    logic [31:0]            r_csent;
    logic [31:0]            r_creq;
    logic                   r_ovalid;
    t_out                   r_out;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    t_entry                 ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [EW-1:0]          ram_rdata;
    t_entry                 rd;
    logic [31:0]            rd_req;
    logic                   take;
    logic [CW:0]            mod_try;
    logic [CW:0]            mod_tot;
    logic [CW+4:0]          cnt_ext;
    logic                   last_issue;

    llrs_ram #(.WIDTH(EW), .DEPTH(MAX_ROUTEES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd         = t_entry'(ram_rdata);
    assign rd_req     = r_reqv[r_pidx] ? rd.request_count : 32'd0;
    assign mod_try    = {r_rem, r_dvd[15]};
    assign mod_tot    = {1'b0, r_total};
    assign cnt_ext    = {5'd0, r_total};
    assign last_issue = (r_idx == r_total - CW'(1));

    // read address sequencing shared by find, shift and select scans
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_idx[AW-1:0];
        if ((r_state == S_FIND || r_state == S_SHIFT || r_state == S_SCAN) && r_issue &&
            !(r_state == S_SCAN && r_cnt == 5'd16)) begin
            ram_re = 1'b1;
            if (r_state == S_SCAN && r_first) begin
                ram_raddr = r_start;
            end
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_k;
        ram_wdata = '0;
        unique case (r_state)
            S_ADD: begin
                ram_we       = (r_status == ST_OK);
                ram_waddr    = r_total[AW-1:0];
                ram_wdata.id = r_in.session_id;
            end
            S_UPD: begin
                ram_we    = 1'b1;
                ram_waddr = r_k;
                ram_wdata = '{r_in.session_id, r_in.buffer_size, r_in.send_time,
                              r_in.sent_count, r_in.request_count};
            end
            S_SHIFT: begin
                ram_we    = r_pv;
                ram_waddr = r_pidx - AW'(1);
                ram_wdata = rd;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // candidate replacement in the select scan
    always_comb begin
        take = 1'b0;
        if (r_mode == MODE_REQUESTS) begin
            take = (rd_req < r_creq);
        end else if (rd.buffer_size == r_cbuf) begin
            take = (r_ctime > rd.send_time) ||
                   ((r_ctime == rd.send_time) && (rd.sent_count < r_csent));
        end else begin
            take = (r_cbuf > rd.buffer_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= 2'd0;
            r_total  <= '0;
            r_reqv   <= '0;
            r_issue  <= 1'b0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            r_pv     <= ram_re;
            r_pidx   <= ram_raddr;
            r_pfirst <= r_first;

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in     <= i_data;
                        r_status <= ST_OK;
                        r_cid    <= '0;
                        r_cbuf   <= '0;
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        unique case (i_data.opcode)
                            OP_ADD: begin
                                if (r_total == CW'(MAX_ROUTEES)) begin
                                    r_status <= ST_FULL;
                                end
                                r_state <= S_ADD;
                            end
                            OP_SELECT: begin
                                r_rem   <= '0;
                                r_dvd   <= i_data.random_value;
                                r_cnt   <= '0;
                                if (r_total == '0) begin
                                    r_status <= ST_NOT_FOUND;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_state <= S_MOD;
                                end
                            end
                            default: begin
                                if (r_total == '0) begin
                                    r_status <= ST_NOT_FOUND;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_issue <= 1'b1;
                                    r_state <= S_FIND;
                                end
                            end
                        endcase
                    end
                end
                S_ADD: begin
                    if (r_status == ST_OK) begin
                        r_total <= r_total + CW'(1);
                        r_reqv  <= '0;
                    end
                    r_state <= S_FIN;
                end
                S_FIND: begin
                    if (r_issue) begin
                        if (last_issue) begin
                            r_issue <= 1'b0;
                        end
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_pv && !r_found && rd.id == r_in.session_id) begin
                        r_found <= 1'b1;
                        r_k     <= r_pidx;
                        r_issue <= 1'b0;
                    end
                    if (!r_issue && !r_pv) begin
                        if (!r_found) begin
                            r_status <= ST_NOT_FOUND;
                            r_state  <= S_FIN;
                        end else if (r_in.opcode == OP_UPDATE) begin
                            r_state <= S_UPD;
                        end else begin
                            r_idx   <= CW'(r_k) + CW'(1);
                            r_issue <= ((CW'(r_k) + CW'(1)) < r_total);
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_UPD: begin
                    r_reqv[r_k] <= 1'b1;
                    r_state     <= S_FIN;
                end
                S_SHIFT: begin
                    if (r_issue) begin
                        if (last_issue) begin
                            r_issue <= 1'b0;
                        end
                        r_idx <= r_idx + CW'(1);
                    end
                    if (!r_issue && !r_pv) begin
                        for (int i = 0; i < MAX_ROUTEES - 1; i++) begin
                            if (i >= int'(r_k)) begin
                                r_reqv[i] <= r_reqv[i + 1];
                            end
                        end
                        r_reqv[MAX_ROUTEES-1] <= 1'b0;
                        r_total <= r_total - CW'(1);
                        r_state <= S_FIN;
                    end
                end
                S_MOD: begin
                    // restoring remainder, one dividend bit a cycle
                    if (mod_try >= mod_tot) begin
                        r_rem <= CW'(mod_try - mod_tot);
                    end else begin
                        r_rem <= mod_try[CW-1:0];
                    end
                    r_dvd <= {r_dvd[14:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd15) begin
                        r_first <= 1'b1;
                        r_issue <= 1'b1;
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt == 5'd16) begin
                        // remainder is ready: mode 2 always starts at entry zero
                        r_start <= (r_mode == MODE_REQUESTS) ? '0 : r_rem[AW-1:0];
                        r_cnt   <= '0;
                    end
                    if (r_issue && r_cnt != 5'd16) begin
                        if (r_first) begin
                            r_first <= 1'b0;
                            if (r_mode == MODE_RANDOM) begin
                                r_issue <= 1'b0;
                            end
                        end else begin
                            if (last_issue) begin
                                r_issue <= 1'b0;
                            end
                            r_idx <= r_idx + CW'(1);
                        end
                    end
                    if (r_pv && (r_pfirst || (r_pidx != r_start && take))) begin
                        r_cid   <= rd.id;
                        r_cbuf  <= rd.buffer_size;
                        r_ctime <= rd.send_time;
                        r_csent <= rd.sent_count;
                        r_creq  <= rd_req;
                    end
                    if (!r_issue && !r_pv) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid                 <= 1'b1;
                        r_out.status             <= r_status;
                        r_out.chosen_session     <= (r_status == ST_OK) ? r_cid : '0;
                        r_out.chosen_buffer_size <= (r_status == ST_OK) ? r_cbuf : '0;
                        r_out.entry_count        <= cnt_ext[4:0];
                        r_state                  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // first scan cycle is spent latching the start index, so the read port idles
    // while r_cnt still shows the finished modulo count
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;
endmodule

@@ design/llrs_ram.sv @@
module llrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
